[hdl/pdll_pkg.sv]
// Package for the positional doubly linked list block.
// Holds commands, status codes, sizes and the sequencer state type. No dependencies.
`default_nettype none
package pdll_pkg;
    localparam int DefCapacity = 32;
    localparam int LinkW = 6;
    localparam logic [LinkW-1:0] NIL = 6'd63;

    typedef enum logic [2:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_COUNT     = 3'd6,
        CMD_LIST      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_WALK_WAIT,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WAIT,
        S_DEL_WR,
        S_LIST_RD,
        S_LIST_WAIT,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

[hdl/pdll_ram.sv]
// Generic simple dual-port synchronous RAM (one write port, one read port) with a registered read.
// No dependencies.
`default_nettype none
module pdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/positional_doubly_linked_list_top.sv]
// Top level of the positional doubly linked list.
// Depends on pdll_pkg and pdll_ram.
//
// Use: one input channel (cmd, value, position) and one result channel
// (status, count, item_value, last), both valid/stall. A command transfer is
// taken only while the sequencer is idle and no result waits in the result
// register; one command is worked at a time.
// Node values and links sit in three RAMs (value, next, prev), one read per
// cycle with a registered read; head, tail, count and the free map are
// flip-flops. A list command gives one result transfer per node (one for
// an empty list). Positional commands walk the links from the head: one
// RAM read, then the next address.
// The result register holds while stall is high; the sequencer waits.
// Reset empties the list at once (free map all set, head/tail NIL); the
// RAMs need no clearing since only written slots are read.
`default_nettype none
module positional_doubly_linked_list_top
    import pdll_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [31:0] value,
    input  wire logic [6:0]         position,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [5:0]              count,
    output logic signed [31:0]      item_value,
    output logic                    last
);
    localparam int AW = $clog2(CAPACITY);

    state_t state_reg, state_next;
    logic [CAPACITY-1:0] free_reg, free_next;
    logic [LinkW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [31:0] val_reg, val_next;
    logic [6:0] pos_reg, pos_next, k_reg, k_next;
    logic [LinkW-1:0] cur_reg, cur_next, a_reg, a_next, b_reg, b_next;
    logic [LinkW-1:0] n_reg, n_next;
    logic ov_reg, ov_next, last_reg, last_next;
    logic [1:0] st_reg, st_next;
    logic [31:0] iv_reg, iv_next;
    logic [1:0] phase_reg, phase_next;

    // RAM ports
    logic v_we, nx_we, pv_we;
    logic [AW-1:0] v_wa, nx_wa, pv_wa, v_ra, nx_ra, pv_ra;
    logic [31:0] v_wd, v_rd;
    logic [LinkW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

    pdll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    pdll_ram #(.WIDTH(LinkW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    pdll_ram #(.WIDTH(LinkW), .DEPTH(CAPACITY)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

    // lowest free slot
    logic [LinkW-1:0] free_idx;
    always_comb
    begin
        free_idx = NIL;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_idx = LinkW'(i);
            end
        end
    end

    function automatic logic ok(input logic [LinkW-1:0] i);
        return i < LinkW'(CAPACITY);
    endfunction

    // a waiting result also holds off the next command: count and the
    // result fields must not move under a stalled transfer
    assign in_stall   = (state_reg != S_IDLE) || ov_reg;
    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign count      = cnt_reg;
    assign item_value = iv_reg;
    assign last       = last_reg;

    logic [6:0] cnt7;
    assign cnt7 = {1'b0, cnt_reg};

    always_comb
    begin
        state_next = state_reg;
        free_next = free_reg; head_next = head_reg; tail_next = tail_reg;
        cnt_next = cnt_reg; cmd_next = cmd_reg; val_next = val_reg;
        pos_next = pos_reg; k_next = k_reg; cur_next = cur_reg;
        a_next = a_reg; b_next = b_reg; n_next = n_reg;
        ov_next = ov_reg; last_next = last_reg; st_next = st_reg; iv_next = iv_reg;
        phase_next = phase_reg;
        v_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        v_wa = '0; nx_wa = '0; pv_wa = '0;
        v_wd = val_reg; nx_wd = '0; pv_wd = '0;
        v_ra = cur_reg[AW-1:0]; nx_ra = cur_reg[AW-1:0]; pv_ra = cur_reg[AW-1:0];
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd_next = cmd; val_next = value; pos_next = position;
                    st_next = ST_OK; iv_next = '0; last_next = 1'b1;
                    unique case (cmd_t'(cmd))
                        CMD_INS_FIRST:
                        begin
                            a_next = NIL; b_next = head_reg; state_next = S_INS_WR;
                        end
                        CMD_INS_LAST:
                        begin
                            a_next = tail_reg; b_next = NIL; state_next = S_INS_WR;
                        end
                        CMD_INS_POS:
                        begin
                            if (position < 7'd1 || position > cnt7 + 7'd1)
                            begin
                                st_next = ST_BAD; state_next = S_OUT;
                            end
                            else if (position == 7'd1)
                            begin
                                a_next = NIL; b_next = head_reg; state_next = S_INS_WR;
                            end
                            else if (position == cnt7 + 7'd1)
                            begin
                                a_next = tail_reg; b_next = NIL; state_next = S_INS_WR;
                            end
                            else if (free_idx == NIL)
                            begin
                                st_next = ST_FULL; state_next = S_OUT;
                            end
                            else
                            begin
                                // walk to position-1, then read its next link
                                cur_next = head_reg; k_next = 7'd1;
                                pos_next = position - 7'd1; state_next = S_WALK;
                            end
                        end
                        CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS:
                        begin
                            if (cnt_reg == 6'd0)
                            begin
                                st_next = ST_EMPTY; state_next = S_OUT;
                            end
                            else if (cmd_t'(cmd) == CMD_DEL_FIRST)
                            begin
                                cur_next = head_reg; state_next = S_DEL_RD;
                            end
                            else if (cmd_t'(cmd) == CMD_DEL_LAST)
                            begin
                                cur_next = tail_reg; state_next = S_DEL_RD;
                            end
                            else if (position < 7'd1 || position > cnt7)
                            begin
                                st_next = ST_BAD; state_next = S_OUT;
                            end
                            else
                            begin
                                cur_next = head_reg; k_next = 7'd1; state_next = S_WALK;
                            end
                        end
                        CMD_COUNT: state_next = S_OUT;
                        default:
                        begin
                            if (cnt_reg == 6'd0)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cur_next = head_reg; k_next = 7'd0; state_next = S_LIST_RD;
                            end
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (k_reg >= pos_reg || !ok(cur_reg))
                begin
                    if (cmd_reg == CMD_INS_POS)
                    begin
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else
                begin
                    state_next = S_WALK_WAIT; // read issued at cur_reg
                end
            end
            S_WALK_WAIT:
            begin
                cur_next = nx_rd; k_next = k_reg + 7'd1; state_next = S_WALK;
            end
            S_INS_RD:
            begin
                // read of next_link[cur] issued; phase 1 takes the registered data
                if (!ok(cur_reg))
                begin
                    st_next = ST_BAD; state_next = S_OUT;
                end
                else if (phase_reg == 2'd0)
                begin
                    phase_next = 2'd1;
                end
                else
                begin
                    phase_next = 2'd0;
                    a_next = cur_reg; b_next = nx_rd; state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                if (free_idx == NIL)
                begin
                    st_next = ST_FULL; state_next = S_OUT;
                end
                else
                begin
                    // write node, then patch a.next and b.prev on two RAMs
                    v_we = 1'b1; v_wa = free_idx[AW-1:0]; v_wd = val_reg;
                    pv_we = 1'b1; pv_wa = free_idx[AW-1:0]; pv_wd = a_reg;
                    nx_we = 1'b1; nx_wa = free_idx[AW-1:0]; nx_wd = b_reg;
                    n_next = free_idx;
                    free_next[free_idx[AW-1:0]] = 1'b0;
                    cnt_next = cnt_reg + 6'd1;
                    state_next = S_DEL_WR; phase_next = 2'd2;
                end
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_WAIT;
            end
            S_DEL_WAIT:
            begin
                a_next = pv_rd; b_next = nx_rd; n_next = cur_reg;
                free_next[cur_reg[AW-1:0]] = 1'b1;
                cnt_next = cnt_reg - 6'd1;
                phase_next = 2'd0;
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                // phase 0: delete patch; phase 2: insert patch (n_reg is new node)
                if (phase_reg == 2'd2)
                begin
                    if (ok(a_reg))
                    begin
                        nx_we = 1'b1; nx_wa = a_reg[AW-1:0]; nx_wd = n_reg;
                    end
                    else
                    begin
                        head_next = n_reg;
                    end
                    if (ok(b_reg))
                    begin
                        pv_we = 1'b1; pv_wa = b_reg[AW-1:0]; pv_wd = n_reg;
                    end
                    else
                    begin
                        tail_next = n_reg;
                    end
                end
                else
                begin
                    if (ok(a_reg))
                    begin
                        nx_we = 1'b1; nx_wa = a_reg[AW-1:0]; nx_wd = b_reg;
                    end
                    else
                    begin
                        head_next = ok(b_reg) ? b_reg : NIL;
                    end
                    if (ok(b_reg))
                    begin
                        pv_we = 1'b1; pv_wa = b_reg[AW-1:0]; pv_wd = a_reg;
                    end
                    else
                    begin
                        tail_next = ok(a_reg) ? a_reg : NIL;
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        head_next = NIL; tail_next = NIL;
                    end
                end
                phase_next = 2'd0;
                state_next = S_OUT;
            end
            S_LIST_RD:
            begin
                if (!ov_reg || !out_stall)
                begin
                    state_next = S_LIST_WAIT;
                end
            end
            S_LIST_WAIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1; st_next = ST_OK; iv_next = v_rd;
                    last_next = !ok(nx_rd) || (k_reg + 7'd1 >= cnt7)
                                || (k_reg + 7'd1 >= 7'(CAPACITY));
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next = nx_rd; k_next = k_reg + 7'd1; state_next = S_LIST_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg  <= '1;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; val_reg <= val_next; pos_reg <= pos_next;
        k_reg <= k_next; cur_reg <= cur_next; a_reg <= a_next; b_reg <= b_next;
        n_reg <= n_next; last_reg <= last_next; st_reg <= st_next; iv_reg <= iv_next;
    end
endmodule
`default_nettype wire

[tb/tb_positional_doubly_linked_list_top.sv]
// Testbench for positional_doubly_linked_list_top: drives list commands with random
// idling and stalls and checks every result against an in-bench list model.
// Depends on pdll_pkg and the block's RTL.
`timescale 1ns / 1ps

import pdll_pkg::*;

typedef struct {
    status_t          status;
    logic [5:0]       count;
    logic signed [31:0] item_value;
    logic             last;
} list_result_t;

class list_scoreboard;
    // List contents front to back; slot allocation does not change what is visible.
    logic signed [31:0] contents[$];
    list_result_t       pending[$];
    int                 errors;

    function new();
        contents.delete();
        pending.delete();
        errors = 0;
    endfunction

    function void push_result(status_t st, logic signed [31:0] v, logic lst);
        list_result_t r;
        r.status     = st;
        r.count      = 6'(contents.size());
        r.item_value = v;
        r.last       = lst;
        pending.push_back(r);
    endfunction

    // Note an accepted command and queue the results it causes.
    function void note_command(cmd_t c, logic signed [31:0] v, logic [6:0] pos);
        int n;
        status_t st;
        n  = contents.size();
        st = ST_OK;
        case (c)
            CMD_INS_FIRST:
                if (n >= DefCapacity) st = ST_FULL;
                else contents.push_front(v);
            CMD_INS_LAST:
                if (n >= DefCapacity) st = ST_FULL;
                else contents.push_back(v);
            CMD_INS_POS:
                // position is checked before room
                if (pos < 1 || pos > n + 1) st = ST_BAD;
                else if (n >= DefCapacity) st = ST_FULL;
                else contents.insert(pos - 1, v);
            CMD_DEL_FIRST:
                if (n == 0) st = ST_EMPTY;
                else void'(contents.pop_front());
            CMD_DEL_LAST:
                if (n == 0) st = ST_EMPTY;
                else void'(contents.pop_back());
            CMD_DEL_POS:
                if (n == 0) st = ST_EMPTY;
                else if (pos < 1 || pos > n) st = ST_BAD;
                else contents.delete(pos - 1);
            CMD_COUNT: ;
            default:
            begin
                if (n == 0)
                    push_result(ST_OK, 0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_result(ST_OK, contents[i], i == n - 1);
                return;
            end
        endcase
        push_result(st, 0, 1'b1);
    endfunction

    function void check_result(logic [1:0] st, logic [5:0] cnt,
                               logic signed [31:0] v, logic lst);
        list_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result: status %0d count %0d value %0d last %0d",
                   st, cnt, v, lst);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (st !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
        end
        if (cnt !== e.count)
        begin
            $error("count: expected %0d, got %0d", e.count, cnt);
            errors++;
        end
        if (v !== e.item_value)
        begin
            $error("item_value: expected %0d, got %0d", e.item_value, v);
            errors++;
        end
        if (lst !== e.last)
        begin
            $error("last: expected %0d, got %0d", e.last, lst);
            errors++;
        end
    endfunction
endclass

module tb_positional_doubly_linked_list_top;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [6:0]         position;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [5:0]         count;
    logic signed [31:0] item_value;
    logic               last;

    list_scoreboard sb;

    // Phase controls for the driving processes.
    logic quiet;       // last part of the run: no idling or stalls
    logic hold_off;    // long receiver hold-off request
    logic stim_done;

    positional_doubly_linked_list_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .count      (count),
        .item_value (item_value),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit: ends the run with an error if it has not finished.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one command transfer; optional idle burst before it.
    task automatic send_command(cmd_t c, logic signed [31:0] v, logic [6:0] pos);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        position <= pos;
        // wait for the transfer edge
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(c, v, pos);
    endtask

    // Random value with frequent extremes so every bit toggles.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, sometimes just out of range or anywhere in 0..127.
    function automatic logic [6:0] rand_position(bit for_insert);
        int n;
        n = sb.contents.size() + (for_insert ? 1 : 0);
        case ($urandom_range(0, 9))
            0: return 7'($urandom_range(0, 127));
            1: return 7'(n + 1);
            2: return 7'd0;
            default: return 7'($urandom_range(1, n > 0 ? n : 1));
        endcase
    endfunction

    task automatic random_commands(int n, int ins_weight);
        cmd_t c;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_weight)
                c = cmd_t'($urandom_range(0, 2));
            else if (r < 85)
                c = cmd_t'($urandom_range(3, 5));
            else if (r < 92)
                c = CMD_COUNT;
            else
                c = CMD_LIST;
            send_command(c, rand_value(),
                         rand_position(c == CMD_INS_POS));
        end
    endtask

    // Receiver: random stall bursts, a long hold-off on request, none when quiet.
    initial
    begin
        int burst;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                out_stall <= 1'b0;
                hold_off  <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result monitor samples at the edge where the transfer happens.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, count, item_value, last);
    end

    initial
    begin
        int wait_cycles;
        sb = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_COUNT;
        value     = 0;
        position  = 0;
        quiet     = 1'b0;
        hold_off  = 1'b0;
        stim_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list cases first.
        send_command(CMD_LIST, 0, 0);
        send_command(CMD_DEL_FIRST, 0, 0);
        send_command(CMD_DEL_LAST, 0, 0);
        send_command(CMD_DEL_POS, 0, 7'd1);
        send_command(CMD_INS_POS, 5, 7'd0);
        send_command(CMD_INS_POS, 5, 7'd2);
        send_command(CMD_INS_POS, 32'sh7fffffff, 7'd1);
        send_command(CMD_DEL_LAST, 0, 0);          // single-node delete
        send_command(CMD_INS_FIRST, 32'sh80000000, 0);
        send_command(CMD_INS_LAST, -1, 0);
        send_command(CMD_INS_POS, 32'sh55555555, 7'd2);
        send_command(CMD_INS_POS, 32'shaaaaaaaa, 7'd4);
        send_command(CMD_LIST, 0, 0);
        send_command(CMD_DEL_POS, 0, 7'd5);
        send_command(CMD_DEL_POS, 0, 7'd127);
        send_command(CMD_DEL_POS, 0, 7'd2);
        send_command(CMD_COUNT, 0, 0);
        send_command(CMD_DEL_FIRST, 0, 0);
        send_command(CMD_LIST, 0, 0);

        // Fill the pool, probe full, and list 32 results under a long hold-off.
        while (sb.contents.size() < DefCapacity)
            send_command(cmd_t'($urandom_range(0, 1)), rand_value(), 0);
        send_command(CMD_INS_FIRST, 1, 0);
        send_command(CMD_INS_POS, 2, 7'd33);
        send_command(CMD_INS_POS, 2, 7'd34);
        hold_off <= 1'b1;
        send_command(CMD_LIST, 0, 0);
        send_command(CMD_COUNT, 0, 0);
        send_command(CMD_DEL_POS, 0, 7'd32);

        // Random: shrink, grow, churn.
        random_commands(15, 30);
        random_commands(20, 65);
        random_commands(15, 45);
        quiet <= 1'b1;
        random_commands(15, 50);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
hdl/pdll_pkg.sv
hdl/pdll_ram.sv
hdl/positional_doubly_linked_list_top.sv
tb/tb_positional_doubly_linked_list_top.sv
